>>> src/assert_macros.svh
// Assertion helpers shared by the modules that check themselves.
// Each macro takes a label, a clock, an active-low reset, a property body and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASD_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASD_ASSERT(label, clk, rst_n, prop, msg)
`define ASD_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> src/asd_pkg.sv
package asd_pkg;

  localparam int unsigned QUEUE_SLOTS_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF  = 16;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] data;
  } out_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted beat
    logic rd_tail;   // read address: 0 = head, 1 = entry before the tail
    logic cap_head;  // keep the head value that has just been read
    logic exec;      // apply the operation and present the result
  } cmd_t;

endpackage

>>> src/asd_ctrl.sv
module asd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output asd_pkg::cmd_t cmd_o
);
  import asd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDH  = 2'd1;
  localparam logic [1:0] S_RDT  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RDH;
        end
      end
      S_RDH: begin
        state_d = S_RDT;
      end
      S_RDT: begin
        cmd_o.rd_tail  = 1'b1;
        cmd_o.cap_head = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> src/asd_datapath.sv
module asd_datapath #(
  parameter int unsigned QUEUE_SLOTS = asd_pkg::QUEUE_SLOTS_DEF,
  parameter int unsigned DATA_WIDTH  = asd_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  asd_pkg::cmd_t cmd_i,
  input  asd_pkg::in_t  req_i,
  output logic          valid_o,
  output asd_pkg::out_t res_o
);
  import asd_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_SLOTS);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(QUEUE_SLOTS - 1);

  logic [DATA_WIDTH-1:0] slots_mem [QUEUE_SLOTS];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] head_val_q;
  logic [PtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0]       rd_addr, wr_addr;
  logic [PtrW-1:0]       head_nxt, head_prv, tail_nxt, tail_prv;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] item_val;
  logic [DATA_WIDTH:0]   pair_sum;
  logic [DATA_WIDTH-1:0] avg;
  logic                  is_empty, is_full;
  in_t                   item_q;
  out_t                  res_q, res_d;
  logic                  valid_q;

  assign head_nxt = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_prv = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_nxt = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_prv = (tail_q == '0) ? LastIdx : tail_q - 1'b1;

  assign is_empty = (head_q == tail_q);
  assign is_full  = (tail_nxt == head_q);

  assign rd_addr  = cmd_i.rd_tail ? tail_prv : head_q;
  assign item_val = (DATA_WIDTH)'(item_q.value);

  // In the execute cycle the read register holds the tail value.
  assign pair_sum = {1'b0, head_val_q} + {1'b0, rdata_q};
  assign avg      = pair_sum[DATA_WIDTH:1];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    wr_en   = 1'b0;
    wr_addr = tail_q;
    res_d   = '0;
    if (cmd_i.exec) begin
      if (item_q.action == ACT_ENQ) begin
        if (is_full) begin
          res_d.status = ST_REFUSED;
        end else if (is_empty || (item_val >= avg)) begin
          wr_en  = 1'b1;
          tail_d = tail_nxt;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_prv;
          head_d  = head_prv;
        end
      end else begin
        if (is_empty) begin
          res_d.status = ST_REFUSED;
        end else begin
          res_d.data = 16'(head_val_q);
          head_d     = head_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_mem[wr_addr] <= item_val;
    end
    rdata_q <= slots_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_i;
    end
    if (cmd_i.cap_head) begin
      head_val_q <= rdata_q;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      valid_q <= cmd_i.exec;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> src/average_split_deque.sv
// Channel  | Handshake        | Payload          | Direction
// ---------+------------------+------------------+----------
// command  | start_i, busy_o  | req_i  (in_t)    | in
// result   | valid_o (strobe) | res_o  (out_t)   | out
//
// Every beat steps through capture, read of the head slot, read of the slot
// before the tail, then execution with the slot write and pointer update.
// The reads are serial because the slot memory has a single read port, read twice per beat.
// The result shows for one cycle after execution; busy_o is already low then.
// Reset clears the head and tail pointers; the slot memory is not cleared.
// The receiver cannot stall, so a result is never held back.
`include "assert_macros.svh"

module average_split_deque #(
  parameter int unsigned QUEUE_SLOTS = asd_pkg::QUEUE_SLOTS_DEF,
  parameter int unsigned DATA_WIDTH  = asd_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  asd_pkg::in_t  req_i,
  output logic          valid_o,
  output asd_pkg::out_t res_o
);
  import asd_pkg::*;

  cmd_t cmd;

  // The sequencer steps each beat through its read and execute cycles.
  asd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // The datapath holds the slot memory, both pointers and the result register.
  asd_datapath #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // An accepted beat always yields its result.
  `ASD_ASSERT(a_result_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##4 valid_o, "result missing after accepted beat")
  // A result is shown for a single cycle only.
  `ASD_ASSERT(a_single_strobe, clk_i, rst_ni, valid_o |=> !valid_o, "result strobe held longer than one cycle")
  // A refused operation never carries data.
  `ASD_ASSERT(a_refused_zero, clk_i, rst_ni, (valid_o && (res_o.status == ST_REFUSED)) |-> (res_o.data == '0), "refused result carries data")
  // The sequencer is idle whenever a result is shown.
  `ASD_NEVER(a_strobe_idle, clk_i, rst_ni, valid_o && busy_o, "result shown while busy")

endmodule
